### rtl/roc_pkg.sv
// ----------------------------------------------------------------------------
// Rate-of-change ring package
// Shared widths, constants, controller states and the ring command struct.
// ----------------------------------------------------------------------------
package roc_pkg;

    // Deepest lookback supported by default.
    localparam int ROC_MAX_PERIODS = 255;

    // Field widths.
    localparam int ROC_SAMPLE_W  = 32;
    localparam int ROC_PERIODS_W = 8;
    localparam logic [ROC_PERIODS_W-1:0] ROC_PERIODS_RESET = 8'd14;

    // Percent scale and fraction bits of the Q16.16 format.
    localparam logic signed [7:0] ROC_PCT_S  = 8'sd100;
    localparam int                ROC_FRAC_W = 16;

    // Difference is 33 bits signed; times 100 the product is 40 bits signed
    // and its magnitude always fits in 39 bits.
    localparam int ROC_DIFF_W = ROC_SAMPLE_W + 1;
    localparam int ROC_PROD_W = 40;
    localparam int ROC_MAG_W  = 39;

    // Serial divider widths: dividend is the magnitude shifted by the fraction.
    localparam int ROC_DIV_NW = ROC_MAG_W + ROC_FRAC_W;
    localparam int ROC_DIV_DW = ROC_SAMPLE_W;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_UPDATE,
        S_CHECK,
        S_RD_NEW,
        S_MUL,
        S_START,
        S_DIV,
        S_FINISH
    } t_state;

    // Commands from the controller to the sample ring.
    typedef struct packed {
        logic update;   // apply restart and write for the current request
        logic restart;  // clear pointer and count first
        logic write;    // store the sample
        logic rd_old;   // read the oldest slot
        logic rd_new;   // read the newest slot
    } t_ring_cmd;

endpackage

### rtl/roc_ring.sv
// ----------------------------------------------------------------------------
// Rate-of-change sample ring
// Holds the last periods+1 samples in a simple dual-port memory with a write
// pointer and a saturating fill count; reads the oldest and newest slots.
// ----------------------------------------------------------------------------
module roc_ring
    import roc_pkg::*;
#(
    parameter int MAX_PERIODS = ROC_MAX_PERIODS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [ROC_PERIODS_W-1:0] i_periods,
    input  t_ring_cmd                i_cmd,
    input  logic [ROC_SAMPLE_W-1:0]  i_wr_data,
    output logic [ROC_SAMPLE_W-1:0]  o_rd_data,
    output logic                     o_enough
);

    localparam int DEPTH = MAX_PERIODS + 1;
    localparam int PW    = $clog2(DEPTH);
    localparam int HW    = $clog2(DEPTH + 1);
    localparam int EW    = (PW > ROC_PERIODS_W) ? PW : ROC_PERIODS_W;

    logic [ROC_SAMPLE_W-1:0] r_mem [DEPTH];
    logic [ROC_SAMPLE_W-1:0] r_rd_data;
    logic [PW-1:0]           r_ptr;
    logic [PW-1:0]           n_ptr;
    logic [HW-1:0]           r_held;
    logic [HW-1:0]           n_held;

    logic [EW-1:0] w_per_ext;
    logic [EW-1:0] w_max_ext;
    logic [PW-1:0] w_eff;
    logic [PW-1:0] w_ptr_base;
    logic [HW-1:0] w_held_base;
    logic [PW-1:0] w_new_idx;
    logic [PW-1:0] w_rd_addr;

    // Lookback limited to the ring depth.
    assign w_per_ext = EW'(i_periods);
    assign w_max_ext = EW'(MAX_PERIODS);
    assign w_eff     = (w_per_ext > w_max_ext) ? w_max_ext[PW-1:0] : w_per_ext[PW-1:0];

    // Pointer and count after an optional restart.
    assign w_ptr_base  = i_cmd.restart ? '0 : r_ptr;
    assign w_held_base = i_cmd.restart ? '0 : r_held;

    // Next pointer and count for a request.
    always_comb begin
        n_ptr  = w_ptr_base;
        n_held = w_held_base;
        if (i_cmd.write) begin
            if (w_ptr_base >= w_eff) begin
                n_ptr = '0;
            end else begin
                n_ptr = w_ptr_base + 1'b1;
            end
            if (w_held_base < HW'(DEPTH)) begin
                n_held = w_held_base + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_held <= '0;
        end else if (i_cmd.update) begin
            r_ptr  <= n_ptr;
            r_held <= n_held;
        end
    end

    // Newest slot sits just behind the pointer, wrapping to the ring end.
    assign w_new_idx = (r_ptr == '0) ? w_eff : r_ptr - 1'b1;
    assign w_rd_addr = i_cmd.rd_new ? w_new_idx : r_ptr;

    // Sample store with one write and one registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && i_cmd.write) begin
            r_mem[w_ptr_base] <= i_wr_data;
        end
        if (i_cmd.rd_old || i_cmd.rd_new) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_enough  = (w_eff != '0) && (r_held > HW'(w_eff));

endmodule

### rtl/roc_div.sv
// ----------------------------------------------------------------------------
// Rate-of-change serial divider
// Unsigned radix-2 restoring divider: one quotient bit per cycle, the
// dividend shifting out of the same register that collects the quotient.
// ----------------------------------------------------------------------------
module roc_div
    import roc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [ROC_DIV_NW-1:0] i_dividend,
    input  logic [ROC_DIV_DW-1:0] i_divisor,
    output logic                  o_done,
    output logic [ROC_DIV_NW-1:0] o_quotient
);

    localparam int CW = $clog2(ROC_DIV_NW + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [ROC_DIV_DW-1:0] r_rem;
    logic [ROC_DIV_NW-1:0] r_nq;
    logic [ROC_DIV_DW-1:0] r_div;

    logic [ROC_DIV_DW:0]   w_shift;
    logic [ROC_DIV_DW:0]   w_trial;
    logic                  w_ge;

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign w_shift = {r_rem, r_nq[ROC_DIV_NW-1]};
    assign w_trial = w_shift - {1'b0, r_div};
    assign w_ge    = ~w_trial[ROC_DIV_DW];

    // Control: count the steps and flag the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(ROC_DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and the combined dividend and quotient shifter.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_nq  <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_trial[ROC_DIV_DW-1:0] : w_shift[ROC_DIV_DW-1:0];
            r_nq  <= {r_nq[ROC_DIV_NW-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_nq;

endmodule

### rtl/rate_of_change_ring.sv
// ----------------------------------------------------------------------------
// Rate-of-change ring
// Percent rate of change of Q16.16 samples over a configurable lookback.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid with o_in_stall carries one request of
// i_sample, i_sample_absent and i_restart. Output channel: o_out_valid with
// i_out_stall carries o_rate_percent and o_result_valid, one per request.
// The lookback register is written through i_cfg_wr_en and i_cfg_wr_data;
// the user must do so only while the block is idle, which it does not enforce.
// One request is handled at a time. Each request first updates the ring;
// with enough samples held, the oldest and newest samples are read, the
// difference times 100 is registered and the serial divider produces one of
// its 55 quotient bits per cycle. Requests with too few samples held skip
// the reads and the divide; a zero oldest sample skips the divide. A new
// request is accepted the cycle after the previous result has been loaded.
// The output register holds a finished result while the receiver stalls and
// the next request is accepted and worked on meanwhile; the controller only
// waits when it has a second result and the register is still occupied.
// Reset clears the write pointer, the sample count and the handshake state,
// and returns the lookback to 14. The sample memory is not cleared.
// ----------------------------------------------------------------------------
module rate_of_change_ring
    import roc_pkg::*;
#(
    parameter int MAX_PERIODS = ROC_MAX_PERIODS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [ROC_PERIODS_W-1:0] i_cfg_wr_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [ROC_SAMPLE_W-1:0]  i_sample,
    input  logic                     i_sample_absent,
    input  logic                     i_restart,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [ROC_SAMPLE_W-1:0]  o_rate_percent,
    output logic                     o_result_valid
);

    t_state r_state;
    t_state n_state;

    logic [ROC_PERIODS_W-1:0]     r_periods;
    logic [ROC_SAMPLE_W-1:0]      r_sample;
    logic                         r_absent;
    logic                         r_restart;
    logic [ROC_SAMPLE_W-1:0]      r_oldest;
    logic signed [ROC_PROD_W-1:0] r_prod;
    logic [ROC_SAMPLE_W-1:0]      r_rate;
    logic                         r_res_valid;
    logic                         r_out_valid;
    logic [ROC_SAMPLE_W-1:0]      r_out_rate;
    logic                         r_out_res_valid;

    t_ring_cmd               w_cmd;
    logic [ROC_SAMPLE_W-1:0] w_rd_data;
    logic                    w_enough;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [ROC_DIV_NW-1:0]   w_quo;
    logic [ROC_DIV_NW-1:0]   w_dividend;
    logic [ROC_DIV_DW-1:0]   w_divisor;
    logic [ROC_PROD_W-1:0]   w_prod_mag;
    logic                    w_neg;
    logic                    w_pos_ovf;
    logic                    w_neg_ovf;
    logic [ROC_SAMPLE_W-1:0] w_sat;

    logic signed [ROC_DIFF_W-1:0] w_diff;
    logic signed [ROC_PROD_W-1:0] w_prod;

    logic w_in_accept;
    logic w_out_accept;
    logic w_load_out;

    assign w_in_accept  = i_in_valid && !o_in_stall;
    assign w_out_accept = r_out_valid && !i_out_stall;

    // Sample ring.
    roc_ring #(
        .MAX_PERIODS (MAX_PERIODS)
    ) u_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_periods  (r_periods),
        .i_cmd      (w_cmd),
        .i_wr_data  (r_sample),
        .o_rd_data  (w_rd_data),
        .o_enough   (w_enough)
    );

    // Difference times the percent scale, registered before the divide.
    assign w_diff = {w_rd_data[ROC_SAMPLE_W-1], w_rd_data}
                  - {r_oldest[ROC_SAMPLE_W-1], r_oldest};
    assign w_prod = w_diff * ROC_PCT_S;

    // Magnitudes for the unsigned divider; the fraction shift is free.
    assign w_prod_mag = r_prod[ROC_PROD_W-1] ? ROC_PROD_W'(-r_prod) : r_prod;
    assign w_dividend = {w_prod_mag[ROC_MAG_W-1:0], {ROC_FRAC_W{1'b0}}};
    assign w_divisor  = r_oldest[ROC_SAMPLE_W-1] ? -r_oldest : r_oldest;
    assign w_neg      = r_prod[ROC_PROD_W-1] ^ r_oldest[ROC_SAMPLE_W-1];

    roc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // Apply the sign and saturate to 32 bits.
    assign w_pos_ovf = (w_quo[ROC_DIV_NW-1:ROC_SAMPLE_W-1] != '0);
    assign w_neg_ovf = (w_quo[ROC_DIV_NW-1:ROC_SAMPLE_W] != '0)
                    || (w_quo[ROC_SAMPLE_W-1] && (w_quo[ROC_SAMPLE_W-2:0] != '0));

    always_comb begin
        if (w_neg) begin
            w_sat = w_neg_ovf ? {1'b1, {(ROC_SAMPLE_W-1){1'b0}}}
                              : -w_quo[ROC_SAMPLE_W-1:0];
        end else begin
            w_sat = w_pos_ovf ? {1'b0, {(ROC_SAMPLE_W-1){1'b1}}}
                              : w_quo[ROC_SAMPLE_W-1:0];
        end
    end

    // Controller: next state and commands.
    always_comb begin
        n_state     = r_state;
        w_cmd       = '0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                w_cmd.update  = 1'b1;
                w_cmd.restart = r_restart;
                w_cmd.write   = !r_absent;
                n_state       = S_CHECK;
            end
            S_CHECK: begin
                if (w_enough) begin
                    w_cmd.rd_old = 1'b1;
                    n_state      = S_RD_NEW;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_RD_NEW: begin
                w_cmd.rd_new = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                n_state = (r_oldest == '0) ? S_FINISH : S_START;
            end
            S_START: begin
                w_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Lookback register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_periods <= ROC_PERIODS_RESET;
        end else if (i_cfg_wr_en) begin
            r_periods <= i_cfg_wr_data;
        end
    end

    // Request capture and working registers.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_sample  <= i_sample;
            r_absent  <= i_sample_absent;
            r_restart <= i_restart;
        end
        if (r_state == S_CHECK) begin
            r_rate      <= '0;
            r_res_valid <= 1'b0;
        end
        if (r_state == S_RD_NEW) begin
            r_oldest <= w_rd_data;
        end
        if (r_state == S_MUL) begin
            r_prod <= w_prod;
        end
        if (r_state == S_DIV && w_div_done) begin
            r_rate      <= w_sat;
            r_res_valid <= 1'b1;
        end
    end

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (w_out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_rate      <= r_rate;
            r_out_res_valid <= r_res_valid;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_rate_percent = r_out_rate;
    assign o_result_valid = r_out_res_valid;

endmodule

### verif/rate_of_change_ring_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rate-of-change ring testbench
// Sends Q16.16 samples with absent and restart flags under several lookback
// settings and checks every percent-change result against a predictor of the
// ring. Sender gaps and receiver stalls are drawn at random per request.
// ----------------------------------------------------------------------------
module rate_of_change_ring_test;
    import roc_pkg::*;

    localparam int RING_SLOTS   = ROC_MAX_PERIODS + 1;
    localparam int RANDOM_ITEMS = 800;
    localparam int MAX_GAP      = 12;
    localparam int SETTLE       = 70;

    typedef logic [ROC_SAMPLE_W-1:0] t_word;

    typedef struct packed {
        t_word rate;
        logic  valid;
    } t_roc_result;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_wr_en;
    logic [ROC_PERIODS_W-1:0] i_cfg_wr_data;
    logic                     i_in_valid;
    logic                     o_in_stall;
    t_word                    i_sample;
    logic                     i_sample_absent;
    logic                     i_restart;
    logic                     o_out_valid;
    logic                     i_out_stall;
    t_word                    o_rate_percent;
    logic                     o_result_valid;

    // Predictor state: a copy of the sample ring and its bookkeeping.
    t_word       ring_copy [RING_SLOTS];
    int unsigned write_slot;
    int unsigned held_count;
    int unsigned lookback;
    bit          restart_pending;

    t_roc_result expected_rates[$];
    int          mismatches;
    int          in_gap_max;
    int          out_gap_max;
    int          out_hold;

    rate_of_change_ring dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_sample        (i_sample),
        .i_sample_absent (i_sample_absent),
        .i_restart       (i_restart),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_rate_percent  (o_rate_percent),
        .o_result_valid  (o_result_valid)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Works out the result of one request and advances the ring copy.
    function automatic t_roc_result percent_change(t_word sample, bit absent, bit restart);
        t_roc_result res;
        int unsigned span;
        int unsigned old_slot;
        int unsigned new_slot;
        longint      oldest;
        longint      newest;
        longint      quotient;
        span = lookback + 1;
        res  = '0;
        if (restart) begin
            held_count = 0;
            write_slot = 0;
        end
        if (!absent) begin
            ring_copy[write_slot] = sample;
            if (held_count < RING_SLOTS)
                held_count++;
            write_slot = (write_slot + 1 >= span) ? 0 : write_slot + 1;
        end
        if (lookback >= 1 && held_count >= span) begin
            old_slot = write_slot;
            new_slot = (write_slot == 0) ? span - 1 : write_slot - 1;
            oldest   = longint'($signed(ring_copy[old_slot]));
            newest   = longint'($signed(ring_copy[new_slot]));
            if (oldest != 0) begin
                quotient = ((newest - oldest) * 100 * 65536) / oldest;
                if (quotient > 64'sd2147483647)
                    quotient = 64'sd2147483647;
                if (quotient < -64'sd2147483648)
                    quotient = -64'sd2147483648;
                res.rate  = quotient[31:0];
                res.valid = 1'b1;
            end
        end
        return res;
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(string what, t_word got, t_word want);
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // Receiver pacing: after each accepted result, stall for a drawn number of cycles.
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall)
            out_hold = $urandom_range(0, out_gap_max);
        else if (out_hold > 0)
            out_hold--;
        i_out_stall <= (out_hold != 0);
    end

    // Result checker: every accepted result is matched with the oldest expectation.
    always @(posedge i_clk) begin : check_result
        t_roc_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_rates.size() == 0) begin
                report_mismatch("result with none expected", o_rate_percent, '0);
            end else begin
                want = expected_rates.pop_front();
                if (o_rate_percent !== want.rate)
                    report_mismatch("rate_percent", o_rate_percent, want.rate);
                if (o_result_valid !== want.valid)
                    report_mismatch("result_valid", t_word'(o_result_valid),
                                    t_word'(want.valid));
            end
        end
    end

    // Sends one request after a drawn gap and records its expected result.
    task automatic send_sample(t_word sample, bit absent, bit restart);
        int gap;
        bit do_restart;
        gap        = $urandom_range(0, in_gap_max);
        do_restart = restart | restart_pending;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_sample        <= sample;
        i_sample_absent <= absent;
        i_restart       <= do_restart;
        do @(posedge i_clk); while (o_in_stall);
        restart_pending = 1'b0;
        expected_rates.push_back(percent_change(sample, absent, do_restart));
    endtask

    // Stops sending and waits until every expected result has arrived.
    task automatic wait_until_idle();
        i_in_valid <= 1'b0;
        while (expected_rates.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes the lookback while idle; the next request then restarts the ring,
    // so no slot left unwritten since the last restart is ever read.
    task automatic write_lookback(int unsigned value);
        wait_until_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value[ROC_PERIODS_W-1:0];
        @(posedge i_clk);
        i_cfg_wr_en     <= 1'b0;
        lookback        = value;
        restart_pending = 1'b1;
    endtask

    // Mixture of sample values: full range, near zero, near the limits, near one.
    function automatic t_word draw_sample();
        case ($urandom_range(0, 5))
            0:       return t_word'($urandom_range(0, 8)) - 32'd4;
            1:       return 32'h7FFF_FFFF - t_word'($urandom_range(0, 3));
            2:       return 32'h8000_0000 + t_word'($urandom_range(0, 3));
            3:       return 32'h0001_0000 + t_word'($urandom_range(0, 65535)) - 32'd32768;
            default: return t_word'($urandom);
        endcase
    endfunction

    // Reset lookback of 14: fifteen samples fill the ring, one absent request between.
    task automatic test_default_lookback();
        t_word fill [15];
        fill = '{32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                 32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
                 32'h0000_FFFF, 32'hFFFF_0000, 32'h1234_5678, 32'hEDCB_A987,
                 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0001_8000};
        for (int k = 0; k < 15; k++) begin
            send_sample(fill[k], 1'b0, 1'b0);
            if (k == 7)
                send_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
        end
    endtask

    // One-sample lookback: saturation both ways, zero divisor, absent and restart.
    task automatic test_extreme_samples();
        write_lookback(1);
        send_sample(32'h0000_0001, 1'b0, 1'b1);
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h1234_5678, 1'b1, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h0000_0000, 1'b0, 1'b0);
        send_sample(32'h0000_0005, 1'b0, 1'b0);
        send_sample(32'h8000_0000, 1'b0, 1'b1);
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h0000_0000, 1'b1, 1'b1);
    endtask

    // Zero lookback: every result is invalid.
    task automatic test_zero_lookback();
        write_lookback(0);
        send_sample(32'h0001_0000, 1'b0, 1'b0);
        send_sample(32'h0002_0000, 1'b0, 1'b0);
        send_sample(32'h0003_0000, 1'b0, 1'b0);
    endtask

    // Random streams under a series of lookbacks, with and without idling.
    task automatic test_random_streams();
        int unsigned settings [4];
        int unsigned value;
        int          phase;
        int          sent;
        int          count;
        settings = '{1, 255, 0, 2};
        phase    = 0;
        sent     = 0;
        while (sent < RANDOM_ITEMS) begin
            if (phase < 4)
                value = settings[phase];
            else if ($urandom_range(0, 3) == 0)
                value = $urandom_range(0, ROC_MAX_PERIODS);
            else
                value = $urandom_range(1, 6);
            write_lookback(value);
            in_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
            out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
            count = (value >= 200) ? value + 40 : $urandom_range(30, 70);
            for (int k = 0; k < count; k++) begin
                // Hold back once mid-stream until the block has drained.
                if (phase == 0 && k == count / 2)
                    wait_until_idle();
                send_sample(draw_sample(), $urandom_range(0, 7) == 0,
                            $urandom_range(0, 29) == 0);
            end
            sent += count;
            phase++;
        end
    endtask

    // Run limit.
    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Test sequence.
    initial begin
        mismatches      = 0;
        out_hold        = 0;
        in_gap_max      = MAX_GAP;
        out_gap_max     = MAX_GAP;
        write_slot      = 0;
        held_count      = 0;
        lookback        = ROC_PERIODS_RESET;
        restart_pending = 1'b0;
        i_rst_n         <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_wr_data   <= '0;
        i_in_valid      <= 1'b0;
        i_sample        <= '0;
        i_sample_absent <= 1'b0;
        i_restart       <= 1'b0;
        i_out_stall     <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_lookback();
        test_extreme_samples();
        test_zero_lookback();
        test_random_streams();

        wait_until_idle();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
